@@ rtl/core/clcd_pkg.sv @@
// shared types, constants and phase tables for the character lcd nibble sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package clcd_pkg;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned BASE_W   = 7;
    localparam int unsigned NIB_W    = 4;
    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned SUB_W    = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned NUM_LINES = 4;

    localparam logic [BYTE_W-1:0] ROW_LAST   = 8'd3;
    localparam logic [BYTE_W-1:0] GOTO_FLAG  = 8'h80;

    localparam logic [IDX_W-1:0] INIT_LAST     = 4'd8;
    localparam logic [IDX_W-1:0] CONF_WAIT_IDX = 4'd4;
    localparam logic [SUB_W-1:0] SUB_LAST      = 3'd5;

    localparam logic [HOLD_W-1:0] HOLD_NONE    = 16'd0;
    localparam logic [HOLD_W-1:0] HOLD_STROBE  = 16'd1;
    localparam logic [HOLD_W-1:0] HOLD_SETTLE  = 16'd4;
    localparam logic [HOLD_W-1:0] HOLD_EXEC    = 16'd160;
    localparam logic [HOLD_W-1:0] HOLD_PWR_UP  = 16'd60000;
    localparam logic [HOLD_W-1:0] HOLD_WAKE1   = 16'd16400;
    localparam logic [HOLD_W-1:0] HOLD_WAKE2   = 16'd400;
    localparam logic [HOLD_W-1:0] HOLD_CLEAR   = 16'd6560;

    localparam logic [NIB_W-1:0] NIB_ZERO  = 4'h0;
    localparam logic [NIB_W-1:0] NIB_WAKE  = 4'h3;
    localparam logic [NIB_W-1:0] NIB_4BIT  = 4'h2;
    localparam logic [NIB_W-1:0] NIB_CLEAR = 4'h1;

    localparam logic [BASE_W-1:0] LINE_BASE_RST [NUM_LINES] = '{7'd0, 7'd64, 7'd20, 7'd84};

    typedef enum logic [CMD_W-1:0] {
        CMD_INIT  = 3'd0,
        CMD_CONF  = 3'd1,
        CMD_INSTR = 3'd2,
        CMD_DATA  = 3'd3,
        CMD_GOTO  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_CONF,
        ST_BYTE
    } t_state;

    typedef enum logic [1:0] {
        SRC_INIT,
        SRC_CONF,
        SRC_BYTE,
        SRC_WAIT
    } t_src;

    // packs with nibble in the lowest bits
    typedef struct packed {
        logic [HOLD_W-1:0] hold;
        logic              en;
        logic              rs;
        logic [NIB_W-1:0]  nibble;
    } t_phase;

    typedef struct packed {
        logic             load;
        logic             emit;
        t_src             src;
        logic [IDX_W-1:0] idx;
        logic [SUB_W-1:0] sub;
        logic             last;
    } t_dp_cmd;

    // power-up wait followed by the wake pulses 3,3,3,2
    function automatic t_phase init_phase(input logic [IDX_W-1:0] idx);
        t_phase p;
        p.rs = 1'b0;
        unique case (idx)
            4'd0: begin p.nibble = NIB_ZERO; p.en = 1'b0; p.hold = HOLD_PWR_UP; end
            4'd1: begin p.nibble = NIB_WAKE; p.en = 1'b1; p.hold = HOLD_STROBE; end
            4'd2: begin p.nibble = NIB_WAKE; p.en = 1'b0; p.hold = HOLD_WAKE1;  end
            4'd3: begin p.nibble = NIB_WAKE; p.en = 1'b1; p.hold = HOLD_STROBE; end
            4'd4: begin p.nibble = NIB_WAKE; p.en = 1'b0; p.hold = HOLD_WAKE2;  end
            4'd5: begin p.nibble = NIB_WAKE; p.en = 1'b1; p.hold = HOLD_STROBE; end
            4'd6: begin p.nibble = NIB_WAKE; p.en = 1'b0; p.hold = HOLD_EXEC;   end
            4'd7: begin p.nibble = NIB_4BIT; p.en = 1'b1; p.hold = HOLD_STROBE; end
            default: begin p.nibble = NIB_4BIT; p.en = 1'b0; p.hold = HOLD_EXEC; end
        endcase
        return p;
    endfunction

    // function set, entry mode, display on, clear
    function automatic logic [BYTE_W-1:0] conf_byte(input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        unique case (idx[1:0])
            2'd0:    b = 8'h28;
            2'd1:    b = 8'h06;
            2'd2:    b = 8'h0C;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/char_lcd_nibble_sequencer.sv @@
// Character LCD nibble sequencer for a 4-bit bus. Each accepted command becomes a run of
// pin phases (nibble, RS, E, hold time in 0.25 us units), the run's final phase marked by
// m_axis_tlast. One command is worked at a time: the sequencer takes a transfer while idle
// and then emits one phase per cycle while the output register drains. Codes 5 to 7 are
// taken and dropped with no output. The user must write the line base registers through
// the cfg port only while no run is in progress; the block itself does not enforce this.
// Depends on clcd_pkg, clcd_ctrl and clcd_dp.
`default_nettype none

module char_lcd_nibble_sequencer
    import clcd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BASE_W-1:0]    i_cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [2:0] command, [10:3] value, [18:11] column, [26:19] row, [31:27] zero
    input  wire logic [31:0]          s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [3:0] nibble, [4] reg_select, [5] enable, [21:6] hold_quarter_us, [23:22] zero
    output logic [23:0]               m_axis_tdata,
    output logic                      m_axis_tlast
);

    t_dp_cmd dp_cmd;
    logic    can_emit;
    logic    in_ready;
    t_phase  out_phase;

    clcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tdata[2:0]),
        .i_can_emit (can_emit),
        .o_in_ready (in_ready),
        .o_dp_cmd   (dp_cmd)
    );

    clcd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (s_axis_tdata[2:0]),
        .i_value     (s_axis_tdata[10:3]),
        .i_column    (s_axis_tdata[18:11]),
        .i_row       (s_axis_tdata[26:19]),
        .i_dp_cmd    (dp_cmd),
        .i_out_ready (m_axis_tready),
        .o_can_emit  (can_emit),
        .o_out_valid (m_axis_tvalid),
        .o_out_phase (out_phase),
        .o_out_last  (m_axis_tlast)
    );

    assign s_axis_tready = in_ready;
    assign m_axis_tdata  = {2'b00, out_phase};

    // a known command starts a run, so the input side closes next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[2:0] <= CMD_GOTO)
        |=> !s_axis_tready)
        else $error("input still open after a command was taken");

    // while idle, anything still waiting at the output must close its run
    a_idle_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
        else $error("idle with an unfinished run at the output");

    // the strobe phase is always one quarter microsecond
    a_strobe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> (m_axis_tdata[21:6] == HOLD_STROBE))
        else $error("strobe phase with wrong hold time");

endmodule

`default_nettype wire

@@ rtl/core/clcd_ctrl.sv @@
// sequencing state machine: walks the phases of each command
// depends on clcd_pkg; drives the datapath through t_dp_cmd
`default_nettype none

module clcd_ctrl
    import clcd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [CMD_W-1:0] i_in_cmd,
    input  wire logic             i_can_emit,
    output logic                  o_in_ready,
    output t_dp_cmd               o_dp_cmd
);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [SUB_W-1:0]   r_sub, n_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_sub   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_sub   <= n_sub;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_idx           = r_idx;
        n_sub           = r_sub;
        o_in_ready      = 1'b0;
        o_dp_cmd.load   = 1'b0;
        o_dp_cmd.emit   = 1'b0;
        o_dp_cmd.src    = SRC_BYTE;
        o_dp_cmd.idx    = r_idx;
        o_dp_cmd.sub    = r_sub;
        o_dp_cmd.last   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                n_idx      = '0;
                n_sub      = '0;
                if (i_in_valid) begin
                    o_dp_cmd.load = 1'b1;
                    case (i_in_cmd)
                        CMD_INIT:                      n_state = ST_INIT;
                        CMD_CONF:                      n_state = ST_CONF;
                        CMD_INSTR, CMD_DATA, CMD_GOTO: n_state = ST_BYTE;
                        default:                       n_state = ST_IDLE;
                    endcase
                end
            end
            ST_INIT: begin
                o_dp_cmd.src  = SRC_INIT;
                o_dp_cmd.last = (r_idx == INIT_LAST);
                if (i_can_emit) begin
                    o_dp_cmd.emit = 1'b1;
                    n_idx = r_idx + 1'b1;
                    if (r_idx == INIT_LAST) n_state = ST_IDLE;
                end
            end
            ST_CONF: begin
                if (r_idx == CONF_WAIT_IDX) begin
                    o_dp_cmd.src  = SRC_WAIT;
                    o_dp_cmd.last = 1'b1;
                end else begin
                    o_dp_cmd.src  = SRC_CONF;
                end
                if (i_can_emit) begin
                    o_dp_cmd.emit = 1'b1;
                    if (r_idx == CONF_WAIT_IDX) begin
                        n_state = ST_IDLE;
                    end else if (r_sub == SUB_LAST) begin
                        n_sub = '0;
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
            end
            ST_BYTE: begin
                o_dp_cmd.src  = SRC_BYTE;
                o_dp_cmd.last = (r_sub == SUB_LAST);
                if (i_can_emit) begin
                    o_dp_cmd.emit = 1'b1;
                    n_sub = r_sub + 1'b1;
                    if (r_sub == SUB_LAST) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/clcd_dp.sv @@
// datapath: line base registers, latched command byte, phase builder and output register
// depends on clcd_pkg; steered by clcd_ctrl
`default_nettype none

module clcd_dp
    import clcd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BASE_W-1:0]    i_cfg_data,
    input  wire logic [CMD_W-1:0]     i_cmd,
    input  wire logic [BYTE_W-1:0]    i_value,
    input  wire logic [BYTE_W-1:0]    i_column,
    input  wire logic [BYTE_W-1:0]    i_row,
    input  wire t_dp_cmd              i_dp_cmd,
    input  wire logic                 i_out_ready,
    output logic                      o_can_emit,
    output logic                      o_out_valid,
    output t_phase                    o_out_phase,
    output logic                      o_out_last
);

    logic [BASE_W-1:0] r_line_base [NUM_LINES];
    logic [BYTE_W-1:0] r_byte;
    logic              r_rs;
    logic              r_out_valid;
    t_phase            r_out_phase;
    logic              r_out_last;

    logic [CFG_IDX_W-1:0] row_sel;
    logic [BYTE_W-1:0]    goto_addr;
    logic [BYTE_W-1:0]    n_byte;
    logic [BYTE_W-1:0]    cur_byte;
    logic [NIB_W-1:0]     hi_nib, lo_nib;
    t_phase               n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LINES; i++) r_line_base[i] <= LINE_BASE_RST[i];
        end else if (i_cfg_we) begin
            r_line_base[i_cfg_index] <= i_cfg_data;
        end
    end

    // rows above the last one fall back to row 0
    assign row_sel   = (i_row > ROW_LAST) ? '0 : i_row[CFG_IDX_W-1:0];
    assign goto_addr = {1'b0, r_line_base[row_sel]} + i_column;
    assign n_byte    = (i_cmd == CMD_GOTO) ? (GOTO_FLAG | goto_addr) : i_value;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_byte <= n_byte;
            r_rs   <= (i_cmd == CMD_DATA);
        end
    end

    assign cur_byte = (i_dp_cmd.src == SRC_CONF) ? conf_byte(i_dp_cmd.idx) : r_byte;
    assign hi_nib   = cur_byte[BYTE_W-1:NIB_W];
    assign lo_nib   = cur_byte[NIB_W-1:0];

    always_comb begin
        n_phase = init_phase(i_dp_cmd.idx);
        unique case (i_dp_cmd.src)
            SRC_INIT: n_phase = init_phase(i_dp_cmd.idx);
            SRC_WAIT: begin
                n_phase.nibble = NIB_CLEAR;
                n_phase.rs     = 1'b0;
                n_phase.en     = 1'b0;
                n_phase.hold   = HOLD_CLEAR;
            end
            default: begin
                // three phases per nibble: set, strobe high, strobe low
                n_phase.rs     = (i_dp_cmd.src == SRC_BYTE) ? r_rs : 1'b0;
                n_phase.nibble = (i_dp_cmd.sub < 3'd3) ? hi_nib : lo_nib;
                case (i_dp_cmd.sub)
                    3'd0, 3'd3: begin n_phase.en = 1'b0; n_phase.hold = HOLD_NONE;   end
                    3'd1, 3'd4: begin n_phase.en = 1'b1; n_phase.hold = HOLD_STROBE; end
                    3'd2:       begin n_phase.en = 1'b0; n_phase.hold = HOLD_SETTLE; end
                    default:    begin n_phase.en = 1'b0; n_phase.hold = HOLD_EXEC;   end
                endcase
            end
        endcase
    end

    assign o_can_emit = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.emit) begin
            r_out_phase <= n_phase;
            r_out_last  <= i_dp_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_phase = r_out_phase;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

@@ tb/clcd_phase_checker.sv @@
// phase checker for the character lcd nibble sequencer: predicts the pin phases of every
// accepted command and compares them with the output stream. depends on clcd_pkg
`timescale 1ns / 1ps

module clcd_phase_checker
    import clcd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BASE_W-1:0]    i_cfg_data,
    input  wire logic                 i_cmd_valid,
    input  wire logic                 i_cmd_ready,
    input  wire logic [31:0]          i_cmd_data,
    input  wire logic                 i_phase_valid,
    input  wire logic                 i_phase_ready,
    input  wire logic [23:0]          i_phase_data,
    input  wire logic                 i_phase_last,
    output int                        o_pending,
    output int                        o_fail_count
);

    localparam logic [HOLD_W-1:0] T_POWER_UP = 16'd60000;
    localparam logic [HOLD_W-1:0] T_WAKE_1   = 16'd16400;
    localparam logic [HOLD_W-1:0] T_WAKE_2   = 16'd400;
    localparam logic [HOLD_W-1:0] T_EXEC     = 16'd160;
    localparam logic [HOLD_W-1:0] T_CLEAR    = 16'd6560;
    localparam logic [HOLD_W-1:0] T_STROBE   = 16'd1;
    localparam logic [HOLD_W-1:0] T_SETTLE   = 16'd4;
    localparam logic [HOLD_W-1:0] T_NONE     = 16'd0;
    localparam logic [BYTE_W-1:0] SET_DDRAM  = 8'h80;

    typedef struct packed {
        logic [NIB_W-1:0]  nibble;
        logic              reg_select;
        logic              enable;
        logic [HOLD_W-1:0] hold_quarter_us;
        logic              last;
    } t_lcd_phase;

    logic [BASE_W-1:0] line_base [NUM_LINES];
    t_lcd_phase        expected_phases [$];
    int                fail_count = 0;

    task automatic queue_phase(input logic [NIB_W-1:0] nib, input logic rs, input logic en,
                               input logic [HOLD_W-1:0] hold, input logic last);
        t_lcd_phase p;
        p.nibble          = nib;
        p.reg_select      = rs;
        p.enable          = en;
        p.hold_quarter_us = hold;
        p.last            = last;
        expected_phases.push_back(p);
    endtask

    // high nibble then low nibble, each set / strobe / hold: settle after the high, execute after the low
    task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic rs, input logic last);
        queue_phase(b[7:4], rs, 1'b0, T_NONE, 1'b0);
        queue_phase(b[7:4], rs, 1'b1, T_STROBE, 1'b0);
        queue_phase(b[7:4], rs, 1'b0, T_SETTLE, 1'b0);
        queue_phase(b[3:0], rs, 1'b0, T_NONE, 1'b0);
        queue_phase(b[3:0], rs, 1'b1, T_STROBE, 1'b0);
        queue_phase(b[3:0], rs, 1'b0, T_EXEC, last);
    endtask

    task automatic queue_wake(input logic [NIB_W-1:0] nib, input logic [HOLD_W-1:0] hold,
                              input logic last);
        queue_phase(nib, 1'b0, 1'b1, T_STROBE, 1'b0);
        queue_phase(nib, 1'b0, 1'b0, hold, last);
    endtask

    task automatic expand_command(input logic [31:0] data);
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] value;
        logic [BYTE_W-1:0] column;
        logic [BYTE_W-1:0] row;
        logic [BASE_W-1:0] base;
        logic [BYTE_W-1:0] addr;
        cmd    = data[2:0];
        value  = data[10:3];
        column = data[18:11];
        row    = data[26:19];
        case (cmd)
            CMD_INIT: begin
                queue_phase(4'h0, 1'b0, 1'b0, T_POWER_UP, 1'b0);
                queue_wake(4'h3, T_WAKE_1, 1'b0);
                queue_wake(4'h3, T_WAKE_2, 1'b0);
                queue_wake(4'h3, T_EXEC, 1'b0);
                queue_wake(4'h2, T_EXEC, 1'b1);
            end
            CMD_CONF: begin
                queue_byte(8'h28, 1'b0, 1'b0);
                queue_byte(8'h06, 1'b0, 1'b0);
                queue_byte(8'h0C, 1'b0, 1'b0);
                queue_byte(8'h01, 1'b0, 1'b0);
                queue_phase(4'h1, 1'b0, 1'b0, T_CLEAR, 1'b1);
            end
            CMD_INSTR: queue_byte(value, 1'b0, 1'b1);
            CMD_DATA:  queue_byte(value, 1'b1, 1'b1);
            CMD_GOTO: begin
                // rows past the last line fall back to line 0
                base = (row < NUM_LINES) ? line_base[row[1:0]] : line_base[0];
                addr = {1'b0, base} + column;
                queue_byte(SET_DDRAM | addr, 1'b0, 1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string field, input int exp_val, input int act_val);
        $error("phase field %s: expected %0d, got %0d", field, exp_val, act_val);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_lcd_phase got;
        t_lcd_phase exp_p;
        if (!i_rst_n) begin
            line_base[0] = 7'd0;
            line_base[1] = 7'd64;
            line_base[2] = 7'd20;
            line_base[3] = 7'd84;
            expected_phases.delete();
        end else begin
            if (i_cfg_we)
                line_base[i_cfg_index] = i_cfg_data;
            // compare before predicting: a phase out now can't stem from a command taken now
            if (i_phase_valid && i_phase_ready) begin
                got.nibble          = i_phase_data[3:0];
                got.reg_select      = i_phase_data[4];
                got.enable          = i_phase_data[5];
                got.hold_quarter_us = i_phase_data[21:6];
                got.last            = i_phase_last;
                if (expected_phases.size() == 0) begin
                    $error("phase transfer with nothing expected: data %h last %b",
                           i_phase_data, i_phase_last);
                    fail_count++;
                end else begin
                    exp_p = expected_phases.pop_front();
                    if (got.nibble !== exp_p.nibble)
                        report_mismatch("nibble", exp_p.nibble, got.nibble);
                    if (got.reg_select !== exp_p.reg_select)
                        report_mismatch("reg_select", exp_p.reg_select, got.reg_select);
                    if (got.enable !== exp_p.enable)
                        report_mismatch("enable", exp_p.enable, got.enable);
                    if (got.hold_quarter_us !== exp_p.hold_quarter_us)
                        report_mismatch("hold_quarter_us", exp_p.hold_quarter_us,
                                        got.hold_quarter_us);
                    if (got.last !== exp_p.last)
                        report_mismatch("last", exp_p.last, got.last);
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                expand_command(i_cmd_data);
        end
        o_pending    <= expected_phases.size();
        o_fail_count <= fail_count;
    end

endmodule

@@ tb/testbench.sv @@
// top of the testbench for char_lcd_nibble_sequencer: clock, reset, command stimulus,
// line base writes and output backpressure. checking lives in clcd_phase_checker
`timescale 1ns / 1ps

module testbench;
    import clcd_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
    localparam logic [BASE_W-1:0] BASE_MAX = 7'd127;
    localparam int IDLE_SETTLE    = 8;     // a dropped code never leaves idle; a run is idle once its last phase is out
    localparam int HOLD_OFF_LEN   = 400;
    localparam int DRAIN_CYCLES   = 40;
    // longest quiet stretch in a good run is the hold-off; random stalls are far shorter
    localparam int WATCHDOG_LIMIT = 5000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BASE_W-1:0]    cfg_data = '0;
    logic                 cmd_tvalid = 1'b0;
    logic                 cmd_tready;
    logic [31:0]          cmd_tdata = '0;
    logic                 phase_tvalid;
    logic                 phase_tready = 1'b0;
    logic [23:0]          phase_tdata;
    logic                 phase_tlast;
    int                   pending_phases;
    int                   fail_count;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_requests = 0;
    int hold_offs_served = 0;
    int quiet_cycles = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    char_lcd_nibble_sequencer dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (cmd_tvalid),
        .s_axis_tready (cmd_tready),
        .s_axis_tdata  (cmd_tdata),
        .m_axis_tvalid (phase_tvalid),
        .m_axis_tready (phase_tready),
        .m_axis_tdata  (phase_tdata),
        .m_axis_tlast  (phase_tlast)
    );

    clcd_phase_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_cmd_valid   (cmd_tvalid),
        .i_cmd_ready   (cmd_tready),
        .i_cmd_data    (cmd_tdata),
        .i_phase_valid (phase_tvalid),
        .i_phase_ready (phase_tready),
        .i_phase_data  (phase_tdata),
        .i_phase_last  (phase_tlast),
        .o_pending     (pending_phases),
        .o_fail_count  (fail_count)
    );

    // receiver: random stalls, plus a long hold-off when the stimulus asks for one
    always @(negedge clk) begin
        if (hold_off_requests != hold_offs_served) begin
            hold_offs_served++;
            phase_tready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(negedge clk);
        end
        phase_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (cmd_tvalid && cmd_tready) || (phase_tvalid && phase_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [7:0] value,
                                input logic [7:0] column, input logic [7:0] row);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            cmd_tvalid <= 1'b0;
            @(negedge clk);
        end
        cmd_tvalid <= 1'b1;
        cmd_tdata  <= {5'd0, row, column, value, cmd};
        do @(posedge clk); while (!cmd_tready);
        @(negedge clk);
    endtask

    task automatic send_random_commands(input int count, input int hold_off_at);
        int sent;
        int pick;
        logic [CMD_W-1:0] cmd;
        logic [7:0] row;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 5)       cmd = CMD_INIT;
            else if (pick < 10) cmd = CMD_CONF;
            else if (pick < 38) cmd = CMD_INSTR;
            else if (pick < 66) cmd = CMD_DATA;
            else if (pick < 95) cmd = CMD_GOTO;
            else                cmd = CMD_RSVD5 + CMD_CW($urandom_range(2));
            row = ($urandom_range(3) != 0) ? 8'($urandom_range(3)) : 8'($urandom);
            if (sent == hold_off_at)
                hold_off_requests++;
            send_command(cmd, 8'($urandom), 8'($urandom), row);
            if (cmd <= CMD_GOTO)
                sent++;
        end
    endtask

    function automatic logic [CMD_W-1:0] CMD_CW(input int unsigned v);
        return v[CMD_W-1:0];
    endfunction

    // registers may only change once every phase is out and the block has gone idle
    task automatic write_line_bases(input logic [BASE_W-1:0] b0, input logic [BASE_W-1:0] b1,
                                    input logic [BASE_W-1:0] b2, input logic [BASE_W-1:0] b3);
        logic [BASE_W-1:0] bases [NUM_LINES];
        bases = '{b0, b1, b2, b3};
        cmd_tvalid <= 1'b0;
        while (pending_phases != 0) @(negedge clk);
        repeat (IDLE_SETTLE) @(negedge clk);
        for (int line = 0; line < NUM_LINES; line++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(line);
            cfg_data  <= bases[line];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every command, field extremes, row fallback, wrapping goto, dropped codes
        send_command(CMD_INIT, 8'h00, 8'h00, 8'h00);
        send_command(CMD_CONF, 8'hFF, 8'hFF, 8'hFF);
        send_command(CMD_INSTR, 8'h00, 8'h00, 8'h00);
        send_command(CMD_INSTR, 8'hFF, 8'hFF, 8'hFF);
        send_command(CMD_DATA, 8'h00, 8'hFF, 8'h00);
        send_command(CMD_DATA, 8'hFF, 8'h00, 8'hFF);
        send_command(CMD_DATA, 8'hA5, 8'h5A, 8'hA5);
        send_command(CMD_INSTR, 8'h5A, 8'hA5, 8'h5A);
        send_command(CMD_GOTO, 8'h00, 8'h00, 8'h00);
        send_command(CMD_GOTO, 8'hFF, 8'h07, 8'h01);
        send_command(CMD_GOTO, 8'h00, 8'hFF, 8'h02);
        send_command(CMD_GOTO, 8'h00, 8'hAC, 8'h03);
        send_command(CMD_GOTO, 8'h00, 8'h05, 8'h04);
        send_command(CMD_GOTO, 8'h00, 8'hC8, 8'hFF);
        send_command(CMD_RSVD5, 8'hFF, 8'hFF, 8'hFF);
        send_command(CMD_RSVD6, 8'h00, 8'h00, 8'h00);
        send_command(CMD_RSVD7, 8'h3C, 8'hC3, 8'h01);
        send_command(CMD_GOTO, 8'h00, 8'h10, 8'h03);
        send_command(CMD_INIT, 8'h00, 8'h00, 8'h00);

        write_line_bases(BASE_MAX, BASE_MAX, BASE_MAX, BASE_MAX);
        send_command(CMD_GOTO, 8'h00, 8'hFF, 8'h02);
        send_command(CMD_GOTO, 8'h00, 8'h81, 8'h03);
        send_command(CMD_GOTO, 8'h00, 8'h80, 8'h09);
        send_random_commands(80, -1);

        write_line_bases('0, '0, '0, '0);
        send_idle_pct = 82;
        send_random_commands(80, -1);

        write_line_bases(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
        send_idle_pct = 0;
        recv_stall_pct = 82;
        send_random_commands(80, -1);

        write_line_bases(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
        send_idle_pct = 35;
        recv_stall_pct = 35;
        send_random_commands(80, 12);

        write_line_bases('0, BASE_MAX, 7'($urandom), 7'($urandom));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random_commands(70, -1);

        cmd_tvalid <= 1'b0;
        while (pending_phases != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_phases == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
